>>> rtl/lbc_pkg.sv
// Package for the LRU block cache policy core: action, error and config index codes, sequencer states.
// No dependencies.
`default_nettype none
package lbc_pkg;
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;
  localparam logic [1:0] ACT_NOP   = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_READ  = 2'd1;
  localparam logic [1:0] ERR_WRITE = 2'd2;

  localparam logic CFG_FS_COUNT = 1'b0;
  localparam logic CFG_BASE     = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UPDATE,
    ST_EMIT,
    ST_FLUSH
  } state_t;
endpackage
`default_nettype wire

>>> rtl/lru_block_cache_policy_core.sv
// Top level of the LRU block cache policy core: sequencer, tag and rank store, counters.
// Depends on lbc_pkg.
`default_nettype none
// A read or write gives its single result after a tag search over the entries (it
// stops at a hit), a decide step, a rank-update step and the result register.
// A flush evicts its entries one at a time, with one rank search each; a flush
// of an empty cache puts its single result out in the cycle after it is accepted.
// busy stays low in the cycle of the last result, so the next transaction can be taken
// at the edge that ends it; one transaction at a time. Reset clears valid bits, fill
// count and counters; the receiver cannot stall.
module lru_block_cache_policy_core #(
  parameter int CAPACITY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_block_number,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic             out_valid,
  output logic             out_hit,
  output logic [1:0]       out_error,
  output logic [32:0]      out_disk_addr,
  output logic             out_disk_access,
  output logic             out_evict_valid,
  output logic [31:0]      out_evicted_block,
  output logic             out_last,
  output logic [4:0]       out_fill_level,
  output logic [31:0]      out_hit_count,
  output logic [31:0]      out_miss_count,
  output logic [31:0]      out_eviction_count
);
  import lbc_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int UW = $clog2(CAPACITY + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [UW-1:0] CAP_U    = UW'(CAPACITY);

  // Tag and rank store; ranks hold 0 for most recent.
  logic [31:0]   tag_r   [CAPACITY];
  logic [IW-1:0] rank_r  [CAPACITY];
  logic [CAPACITY-1:0] valid_r;
  logic [UW-1:0] used_r;
  logic [31:0]   hits_r, misses_r, evicts_r;
  logic [31:0]   fs_count_r, base_r;

  state_t        state_r, state_nxt;
  logic [1:0]    act_r;
  logic [31:0]   num_r;
  logic [IW-1:0] idx_r;         // scan pointer for the shared compare unit
  logic          found_r;
  logic [IW-1:0] slot_r;        // slot found by the scan
  logic          free_found_r;
  logic [IW-1:0] free_r;        // first invalid slot

  // Result register.
  logic          o_valid_r, o_hit_r, o_acc_r, o_ev_r, o_last_r;
  logic          o_valid_nxt;
  logic [1:0]    o_err_r;
  logic [32:0]   o_disk_r;
  logic [31:0]   o_evb_r;

  // The single shared comparator: tag match for a lookup, rank match for a flush.
  logic          cmp_hit;
  logic [IW-1:0] flush_rank;
  assign flush_rank = IW'(used_r - UW'(1));
  always_comb begin
    if (state_r == ST_FLUSH) cmp_hit = valid_r[idx_r] && (rank_r[idx_r] == flush_rank);
    else cmp_hit = valid_r[idx_r] && (tag_r[idx_r] == num_r);
  end

  logic in_range;
  assign in_range = (fs_count_r != 32'd0) && (num_r < fs_count_r);

  logic scan_end;
  assign scan_end = (idx_r == LAST_IDX);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // A flush of an empty cache answers at once and needs no search.
          if (in_action == ACT_FLUSH) state_nxt = (used_r == '0) ? ST_IDLE : ST_FLUSH;
          else if (in_action == ACT_NOP) state_nxt = ST_EMIT;
          else state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: if (scan_end || (cmp_hit && !found_r)) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_IDLE;
      ST_EMIT:   state_nxt = ST_IDLE;
      ST_FLUSH:  if (used_r == '0 || cmp_hit) state_nxt = (used_r <= UW'(1)) ? ST_IDLE : ST_FLUSH;
                 else if (scan_end) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // A result is strobed in the cycle after any state that completes one.
  always_comb begin
    case (state_r)
      ST_IDLE:           o_valid_nxt = start && (in_action == ACT_FLUSH) && (used_r == '0);
      ST_UPDATE, ST_EMIT: o_valid_nxt = 1'b1;
      ST_FLUSH:          o_valid_nxt = (used_r != '0) && cmp_hit;
      default:           o_valid_nxt = 1'b0;
    endcase
  end

  // Decision for read and write, made once the scan is done.
  logic d_hit, d_insert, d_drop, d_front, d_evict, d_acc;
  logic [1:0] d_err;
  always_comb begin
    d_hit = found_r; d_insert = 1'b0; d_drop = 1'b0; d_front = 1'b0; d_acc = 1'b0;
    d_err = ERR_OK;
    if (found_r) begin
      if (act_r == ACT_WRITE && !in_range) begin
        d_drop = 1'b1; d_err = ERR_WRITE;
      end else begin
        d_front = 1'b1; d_acc = (act_r == ACT_WRITE);
      end
    end else if (!in_range) begin
      d_err = (act_r == ACT_WRITE) ? ERR_WRITE : ERR_READ;
    end else begin
      d_insert = 1'b1; d_acc = 1'b1;
    end
    d_evict = d_insert && (used_r >= CAP_U);
  end

  // Victim for an insert into a full cache: the slot with the oldest rank.
  logic [IW-1:0] victim_slot;
  always_comb begin
    victim_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (valid_r[i] && rank_r[i] == LAST_IDX) victim_slot = IW'(i);
  end

  logic [IW-1:0] tgt_slot;
  assign tgt_slot = d_evict ? victim_slot : (free_found_r ? free_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; valid_r <= '0; used_r <= '0;
      hits_r <= '0; misses_r <= '0; evicts_r <= '0;
      fs_count_r <= '0; base_r <= '0; o_valid_r <= 1'b0;
      found_r <= 1'b0; free_found_r <= 1'b0; idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      o_valid_r <= o_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_FS_COUNT) fs_count_r <= cfg_data;
        else base_r <= cfg_data;
      end
      case (state_r)
        ST_IDLE: begin
          idx_r <= '0; found_r <= 1'b0; free_found_r <= 1'b0;
          if (start) begin
            act_r <= in_action; num_r <= in_block_number;
            if (in_action == ACT_FLUSH && used_r == '0) begin
              o_hit_r <= 1'b0; o_err_r <= ERR_OK; o_disk_r <= '0;
              o_acc_r <= 1'b0; o_ev_r <= 1'b0; o_evb_r <= '0; o_last_r <= 1'b1;
            end
          end
        end
        ST_SEARCH: begin
          if (cmp_hit && !found_r) begin
            found_r <= 1'b1; slot_r <= idx_r;
          end
          if (!valid_r[idx_r] && !free_found_r) begin
            free_found_r <= 1'b1; free_r <= idx_r;
          end
          if (!scan_end) idx_r <= idx_r + IW'(1);
        end
        ST_DECIDE: begin
          if (d_hit) hits_r <= hits_r + 32'd1;
          else misses_r <= misses_r + 32'd1;
          o_hit_r <= d_hit; o_err_r <= d_err; o_acc_r <= d_acc;
          o_disk_r <= d_acc ? ({1'b0, base_r} + {1'b0, num_r}) : 33'd0;
          o_ev_r <= d_evict; o_evb_r <= d_evict ? tag_r[victim_slot] : 32'd0;
          o_last_r <= 1'b1;
          if (d_evict) evicts_r <= evicts_r + 32'd1;
          slot_r <= d_insert ? tgt_slot : slot_r;
          found_r <= d_front || d_insert;       // reused: entry goes to front
          free_found_r <= d_drop;               // reused: entry is dropped
          idx_r <= (d_insert) ? LAST_IDX : rank_r[slot_r];  // aging limit
          if (d_insert) begin
            tag_r[tgt_slot] <= num_r;
            if (!d_evict) used_r <= used_r + UW'(1);
          end
        end
        ST_UPDATE: begin
          // Parallel rank update over independent entries.
          for (int i = 0; i < CAPACITY; i++) begin
            if (found_r) begin
              if (IW'(i) == slot_r) rank_r[i] <= '0;
              else if (valid_r[i] && (rank_r[i] < idx_r || idx_r == LAST_IDX &&
                       act_r != ACT_NOP && rank_r[i] != LAST_IDX))
                rank_r[i] <= rank_r[i] + IW'(1);
            end else if (free_found_r) begin
              if (valid_r[i] && IW'(i) != slot_r && rank_r[i] > rank_r[slot_r])
                rank_r[i] <= rank_r[i] - IW'(1);
            end
          end
          if (found_r) valid_r[slot_r] <= 1'b1;
          if (free_found_r) begin
            valid_r[slot_r] <= 1'b0; used_r <= used_r - UW'(1);
          end
        end
        ST_EMIT: begin
          o_hit_r <= 1'b0; o_err_r <= ERR_OK; o_disk_r <= '0;
          o_acc_r <= 1'b0; o_ev_r <= 1'b0; o_evb_r <= '0; o_last_r <= 1'b1;
        end
        ST_FLUSH: begin
          if (used_r != '0) begin
            if (cmp_hit) begin
              valid_r[idx_r] <= 1'b0; used_r <= used_r - UW'(1);
              evicts_r <= evicts_r + 32'd1;
              o_hit_r <= 1'b0; o_err_r <= ERR_OK; o_disk_r <= '0;
              o_acc_r <= 1'b0; o_ev_r <= 1'b1; o_evb_r <= tag_r[idx_r];
              o_last_r <= (used_r == UW'(1));
              idx_r <= '0;
            end else if (!scan_end) idx_r <= idx_r + IW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid          = o_valid_r;
  assign out_hit            = o_hit_r;
  assign out_error          = o_err_r;
  assign out_disk_addr      = o_disk_r;
  assign out_disk_access    = o_acc_r;
  assign out_evict_valid    = o_ev_r;
  assign out_evicted_block  = o_evb_r;
  assign out_last           = o_last_r;
  assign out_fill_level     = 5'(used_r);
  assign out_hit_count      = hits_r;
  assign out_miss_count     = misses_r;
  assign out_eviction_count = evicts_r;
endmodule
`default_nettype wire

>>> rtl/lbc_checker.sv
// Port-level checker for the LRU block cache policy core, with its bind statement.
// Depends on lbc_pkg and the top level lru_block_cache_policy_core.
`default_nettype none
module lbc_checker (
  input wire logic clk, rst_n, start, busy, out_valid, out_last, out_evict_valid,
  input wire logic out_hit, out_disk_access,
  input wire logic [1:0] out_error
);
  import lbc_pkg::*;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("start not taken");
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_evict_valid) else $error("hit with eviction");
  a_err_no_disk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error != ERR_OK) |-> !out_disk_access) else $error("error with disk");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("busy after last");
endmodule
bind lru_block_cache_policy_core lbc_checker u_lbc_checker (.*);
`default_nettype wire
